// ----- design/npc_pkg.sv -----
// Shared types and constants for the nearest palette color block.
// No dependencies; imported by every module of the block.
`default_nettype none

package npc_pkg;

  localparam int PALETTE_DEPTH = 64;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int CHAN_W        = 8;
  localparam int DIST_W        = 10;
  localparam int SIZE_W        = 7;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // control word from the sequencer to the distance unit
  typedef struct packed {
    logic             en;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] idx;
  } cmp_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

`default_nettype wire

// ----- design/npc_palette_mem.sv -----
// Palette storage: one write port, one read port with registered data.
// Depends on npc_pkg.
`default_nettype none

module npc_palette_mem (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [npc_pkg::IDX_W-1:0] wr_addr,
  input  wire npc_pkg::rgb_t            wr_data,
  input  wire logic [npc_pkg::IDX_W-1:0] rd_addr,
  output npc_pkg::rgb_t                 rd_data
);
  import npc_pkg::*;

  rgb_t mem [PALETTE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- design/npc_dist_unit.sv -----
// Shared distance unit: one Manhattan distance and one compare per cycle,
// keeping the running best index and distance. Depends on npc_pkg.
`default_nettype none

module npc_dist_unit (
  input  wire logic                      clk,
  input  wire npc_pkg::cmp_ctl_t         cmp,
  input  wire npc_pkg::rgb_t             entry,
  input  wire npc_pkg::rgb_t             pixel,
  output logic [npc_pkg::IDX_W-1:0]      best_index,
  output logic [npc_pkg::DIST_W-1:0]     best_distance
);
  import npc_pkg::*;

  logic [CHAN_W-1:0] gap_r, gap_g, gap_b;
  logic [DIST_W-1:0] cur_dist;
  logic              take;

  always_comb begin
    gap_r = (entry.red   > pixel.red)   ? entry.red   - pixel.red   : pixel.red   - entry.red;
    gap_g = (entry.green > pixel.green) ? entry.green - pixel.green : pixel.green - entry.green;
    gap_b = (entry.blue  > pixel.blue)  ? entry.blue  - pixel.blue  : pixel.blue  - entry.blue;
    cur_dist = DIST_W'(gap_r) + DIST_W'(gap_g) + DIST_W'(gap_b);
    // strict compare: lower index wins on a tie
    take  = cmp.first || (cur_dist < best_distance);
  end

  always_ff @(posedge clk) begin
    if (cmp.en && take) begin
      best_index    <= cmp.idx;
      best_distance <= cur_dist;
    end
  end

endmodule

`default_nettype wire

// ----- design/nearest_palette_color.sv -----
// Nearest palette color: write items load palette entries, query items
// return the closest entry by sum of absolute RGB differences.
// Write: busy stays low. Query: N = clamped palette_size entries, one per
// cycle through the shared distance unit; result_valid pulses with the last
// compare and busy drops the same cycle. Synchronous reset clears control
// and sets palette_size to 1; palette contents are not cleared. The
// receiver cannot stall results.
`default_nettype none

module nearest_palette_color (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       operation,
  input  wire logic [npc_pkg::IDX_W-1:0]  entry_index,
  input  wire logic [npc_pkg::CHAN_W-1:0] red_level,
  input  wire logic [npc_pkg::CHAN_W-1:0] green_level,
  input  wire logic [npc_pkg::CHAN_W-1:0] blue_level,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [npc_pkg::SIZE_W-1:0] palette_size,
  output logic                            result_valid,
  output logic [npc_pkg::IDX_W-1:0]       best_index,
  output logic [npc_pkg::DIST_W-1:0]      best_distance
);
  import npc_pkg::*;

  state_t             state, state_next;
  logic [SIZE_W-1:0]  size_reg;
  logic [SIZE_W-1:0]  size_eff;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   last_addr;
  logic [IDX_W-1:0]   last_calc;
  rgb_t               pixel;
  rgb_t               in_rgb;
  rgb_t               rd_data;
  cmp_ctl_t           cmp;
  logic               accept;
  logic               wr_en;

  assign in_rgb    = '{red: red_level, green: green_level, blue: blue_level};
  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign accept    = start && !busy;
  assign wr_en     = accept && (operation == OP_WRITE);

  // a size word taken on the same edge as a query applies to that query
  assign size_eff  = (cfg_valid && cfg_ready) ? palette_size : size_reg;

  // size 0 searches entry 0; sizes past the depth saturate
  always_comb begin
    if (size_eff == '0) begin
      last_calc = '0;
    end else if (size_eff > SIZE_W'(PALETTE_DEPTH)) begin
      last_calc = IDX_W'(PALETTE_DEPTH - 1);
    end else begin
      last_calc = IDX_W'(size_eff - SIZE_W'(1));
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && operation == OP_QUERY) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (rd_addr == last_addr) state_next = S_FINISH;
      end
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      size_reg     <= SIZE_W'(1);
      cmp.en       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      if (cfg_valid && cfg_ready) size_reg <= palette_size;
      cmp.en       <= (state == S_SCAN);
      cmp.first    <= (rd_addr == '0);
      cmp.last     <= (rd_addr == last_addr);
      cmp.idx      <= rd_addr;
      result_valid <= cmp.en && cmp.last;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (accept && operation == OP_QUERY) begin
      pixel     <= in_rgb;
      last_addr <= last_calc;
      rd_addr   <= '0;
    end else if (state == S_SCAN) begin
      rd_addr <= rd_addr + IDX_W'(1);
    end
  end

  npc_palette_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (entry_index),
    .wr_data (in_rgb),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  npc_dist_unit u_dist (
    .clk           (clk),
    .cmp           (cmp),
    .entry         (rd_data),
    .pixel         (pixel),
    .best_index    (best_index),
    .best_distance (best_distance)
  );

endmodule

`default_nettype wire

// ----- design/npc_checker.sv -----
// Port-level checks for nearest_palette_color, bound to the top level.
// Depends on npc_pkg.
`default_nettype none

module npc_port_checks (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       operation,
  input wire logic                       result_valid,
  input wire logic [npc_pkg::DIST_W-1:0] best_distance
);
  import npc_pkg::*;

  // each query passes through the scan and finish states before its strobe, so strobes never abut
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("result strobes back to back");

  // nothing accepted can be followed at once by a result
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !result_valid) else $error("result right after accept");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == OP_QUERY) |=> busy)
    else $error("query did not raise busy");

  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (best_distance <= DIST_W'(765)))
    else $error("distance out of range");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!result_valid && !busy)) else $error("activity after reset");

endmodule

bind nearest_palette_color npc_port_checks u_npc_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .operation     (operation),
  .result_valid  (result_valid),
  .best_distance (best_distance)
);

`default_nettype wire

// ----- test/npc_checker.sv -----
// Scoreboard for nearest_palette_color: tracks palette writes and size updates,
// predicts each query's closest entry and compares it with the strobed results.
// Depends on npc_pkg for widths, the color struct and operation codes.
`timescale 1ns / 100ps

module npc_checker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic                       busy,
  input  wire logic                       operation,
  input  wire logic [npc_pkg::IDX_W-1:0]  entry_index,
  input  wire logic [npc_pkg::CHAN_W-1:0] red_level,
  input  wire logic [npc_pkg::CHAN_W-1:0] green_level,
  input  wire logic [npc_pkg::CHAN_W-1:0] blue_level,
  input  wire logic                       cfg_valid,
  input  wire logic                       cfg_ready,
  input  wire logic [npc_pkg::SIZE_W-1:0] palette_size,
  input  wire logic                       result_valid,
  input  wire logic [npc_pkg::IDX_W-1:0]  best_index,
  input  wire logic [npc_pkg::DIST_W-1:0] best_distance,
  output int                              errors,
  output int                              waiting
);
  import npc_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] dist_val;
  } match_t;

  rgb_t              palette_copy [PALETTE_DEPTH];
  logic [SIZE_W-1:0] size_reg;
  match_t            match_q [$];

  initial begin
    errors  = 0;
    waiting = 0;
    foreach (palette_copy[i]) palette_copy[i] = '0;
  end

  function automatic logic [DIST_W-1:0] chan_gap(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
    return (a > b) ? DIST_W'(a - b) : DIST_W'(b - a);
  endfunction

  // strict compare keeps the lowest index on ties
  function automatic match_t nearest_entry(rgb_t px);
    int                count;
    logic [DIST_W-1:0] d;
    match_t            m;
    count = int'(size_reg);
    if (count == 0) count = 1;
    if (count > PALETTE_DEPTH) count = PALETTE_DEPTH;
    m.idx  = '0;
    m.dist_val = chan_gap(palette_copy[0].red, px.red)
               + chan_gap(palette_copy[0].green, px.green)
               + chan_gap(palette_copy[0].blue, px.blue);
    for (int i = 1; i < count; i++) begin
      d = chan_gap(palette_copy[i].red, px.red) + chan_gap(palette_copy[i].green, px.green)
        + chan_gap(palette_copy[i].blue, px.blue);
      if (d < m.dist_val) begin
        m.dist_val = d;
        m.idx      = IDX_W'(i);
      end
    end
    return m;
  endfunction

  always @(posedge clk) begin
    match_t want;
    if (rst) begin
      size_reg = SIZE_W'(1);
      match_q.delete();
    end else begin
      if (result_valid) begin
        if (match_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got index %0d distance %0d",
                   $time, best_index, best_distance);
        end else begin
          want = match_q.pop_front();
          if (best_index !== want.idx) begin
            errors++;
            $display("%0t: best_index expected %0d got %0d", $time, want.idx, best_index);
          end
          if (best_distance !== want.dist_val) begin
            errors++;
            $display("%0t: best_distance expected %0d got %0d", $time, want.dist_val,
                     best_distance);
          end
        end
      end
      if (cfg_valid && cfg_ready) size_reg = palette_size;
      if (start && !busy) begin
        if (operation == OP_WRITE)
          palette_copy[entry_index] = '{red: red_level, green: green_level, blue: blue_level};
        else
          match_q.push_back(nearest_entry('{red: red_level, green: green_level,
                                             blue: blue_level}));
      end
    end
    waiting = match_q.size();
  end

endmodule

// ----- test/nearest_palette_color_test.sv -----
// Top of the nearest_palette_color testbench: clock, reset, stimulus and verdict.
// Depends on npc_pkg, the nearest_palette_color block and npc_checker.
`timescale 1ns / 100ps

module nearest_palette_color_test;
  import npc_pkg::*;

  localparam int ITEMS       = 700;
  localparam int WATCH_LIMIT = 1000;
  localparam int SETTLE      = PALETTE_DEPTH + 8;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              operation = OP_WRITE;
  logic [IDX_W-1:0]  entry_index = '0;
  logic [CHAN_W-1:0] red_level = '0;
  logic [CHAN_W-1:0] green_level = '0;
  logic [CHAN_W-1:0] blue_level = '0;
  logic              cfg_valid = 1'b0;
  logic [SIZE_W-1:0] palette_size = SIZE_W'(1);
  logic              busy;
  logic              cfg_ready;
  logic              result_valid;
  logic [IDX_W-1:0]  best_index;
  logic [DIST_W-1:0] best_distance;

  int   errors;
  int   waiting;
  int   quiet = 0;
  int   sent = 0;
  bit   steady = 1'b0;
  rgb_t shade [PALETTE_DEPTH];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nearest_palette_color u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .entry_index  (entry_index),
    .red_level    (red_level),
    .green_level  (green_level),
    .blue_level   (blue_level),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .palette_size (palette_size),
    .result_valid (result_valid),
    .best_index   (best_index),
    .best_distance(best_distance)
  );

  npc_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .entry_index  (entry_index),
    .red_level    (red_level),
    .green_level  (green_level),
    .blue_level   (blue_level),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .palette_size (palette_size),
    .result_valid (result_valid),
    .best_index   (best_index),
    .best_distance(best_distance),
    .errors       (errors),
    .waiting      (waiting)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || result_valid) begin
      quiet <= 0;
    end else if (quiet + 1 >= WATCH_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet + 1);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [CHAN_W-1:0] nudge(logic [CHAN_W-1:0] v);
    int d;
    int t;
    d = $urandom_range(6);
    t = int'(v) + d - 3;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return CHAN_W'(t);
  endfunction

  // mix of saturated channels, near-misses of existing entries and plain random
  function automatic rgb_t pick_color();
    rgb_t c;
    rgb_t base;
    int   mode;
    mode = $urandom_range(99);
    c = rgb_t'(24'($urandom()));
    if (mode < 20) begin
      c.red   = $urandom_range(1) ? 8'hFF : 8'h00;
      c.green = $urandom_range(1) ? 8'hFF : 8'h00;
      c.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
    end else if (mode < 60) begin
      base    = shade[$urandom_range(PALETTE_DEPTH - 1)];
      c.red   = nudge(base.red);
      c.green = nudge(base.green);
      c.blue  = nudge(base.blue);
    end
    return c;
  endfunction

  task automatic send_item(logic op, logic [IDX_W-1:0] idx, rgb_t c);
    int k;
    @(negedge clk);
    if (!steady && $urandom_range(99) < 10) begin
      k = $urandom_range(6, 1);
      start <= 1'b0;
      repeat (k) @(negedge clk);
    end
    start       <= 1'b1;
    operation   <= op;
    entry_index <= idx;
    red_level   <= c.red;
    green_level <= c.green;
    blue_level  <= c.blue;
    do @(posedge clk); while (busy);
    if (op == OP_WRITE) shade[idx] = c;
    sent++;
  endtask

  // stop sending and let every pending result and any write in flight finish
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (waiting != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_size(logic [SIZE_W-1:0] v);
    drain();
    cfg_valid    <= 1'b1;
    palette_size <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [SIZE_W-1:0] sizes [8];
    int                n;
    rgb_t              c;
    foreach (shade[i]) shade[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: corners, ties, size zero
    send_item(OP_WRITE, IDX_W'(0), rgb_t'(24'h000000));
    send_item(OP_QUERY, IDX_W'(63), rgb_t'(24'hFFFFFF));
    send_item(OP_QUERY, IDX_W'(0), rgb_t'(24'h000000));
    send_item(OP_WRITE, IDX_W'(1), rgb_t'(24'hFFFFFF));
    send_item(OP_WRITE, IDX_W'(2), rgb_t'(24'hFFFFFF));
    send_item(OP_WRITE, IDX_W'(3), rgb_t'(24'h020000));
    send_item(OP_WRITE, IDX_W'(63), rgb_t'(24'hAA55AA));
    set_size(SIZE_W'(0));
    send_item(OP_QUERY, IDX_W'(5), rgb_t'(24'hFFFFFF));
    set_size(SIZE_W'(4));
    send_item(OP_QUERY, IDX_W'(0), rgb_t'(24'hFFFFFF));
    send_item(OP_QUERY, IDX_W'(42), rgb_t'(24'h010000));
    send_item(OP_QUERY, IDX_W'(21), rgb_t'(24'h020000));
    send_item(OP_QUERY, IDX_W'(0), rgb_t'(24'h808080));
    send_item(OP_QUERY, IDX_W'(0), rgb_t'(24'h7F7F7F));
    send_item(OP_QUERY, IDX_W'(0), rgb_t'(24'hFF00FF));
    send_item(OP_QUERY, IDX_W'(0), rgb_t'(24'h00FF00));

    // load every slot so any size can be searched
    for (int i = 0; i < PALETTE_DEPTH; i++) send_item(OP_WRITE, IDX_W'(i), pick_color());

    sizes[0] = SIZE_W'(PALETTE_DEPTH);
    sizes[1] = SIZE_W'(127);
    sizes[2] = SIZE_W'(1);
    sizes[3] = SIZE_W'($urandom_range(PALETTE_DEPTH - 1, 2));
    sizes[4] = SIZE_W'(0);
    sizes[5] = SIZE_W'($urandom_range(126, PALETTE_DEPTH + 1));
    sizes[6] = SIZE_W'($urandom_range(8, 2));
    sizes[7] = SIZE_W'($urandom_range(127));

    for (int p = 0; p < 8; p++) begin
      set_size(sizes[p]);
      n = (ITEMS - sent) / (8 - p);
      for (int j = 0; j < n; j++) begin
        steady = (sent >= 300 && sent < 420);
        if (p == 3 && j == n / 2) drain();
        if ($urandom_range(99) < 30) begin
          c = ($urandom_range(99) < 15) ? shade[$urandom_range(PALETTE_DEPTH - 1)]
                                        : pick_color();
          send_item(OP_WRITE, IDX_W'($urandom_range(PALETTE_DEPTH - 1)), c);
        end else begin
          send_item(OP_QUERY, IDX_W'($urandom_range(PALETTE_DEPTH - 1)), pick_color());
        end
      end
    end

    drain();
    repeat (SETTLE) @(negedge clk);
    if (errors == 0 && waiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (waiting != 0) $display("%0t: %0d results never arrived", $time, waiting);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- nearest_palette_color.f -----
design/npc_pkg.sv
design/npc_palette_mem.sv
design/npc_dist_unit.sv
design/nearest_palette_color.sv
design/npc_checker.sv
test/npc_checker.sv
test/nearest_palette_color_test.sv
